### hdl/rre_pkg.sv
package rre_pkg;

  localparam int unsigned MaxRowDefault   = 4096;
  localparam int unsigned MaxChunkDefault = 126;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 13;
  localparam int unsigned RemW  = 7;

  localparam logic [ByteW-1:0] LitHeader  = 8'h80;
  localparam logic [ByteW-1:0] Terminator = 8'h00;

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqRead = 1'b1;

  typedef enum logic [1:0] {
    KindStart = 2'd0,
    KindLit   = 2'd1,
    KindRun   = 2'd2
  } kind_e;

  typedef enum logic [4:0] {
    StIdle    = 5'b00001,
    StDecide  = 5'b00010,
    StLitOut  = 5'b00100,
    StLitScan = 5'b01000,
    StRunScan = 5'b10000
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] code_byte;
    logic             last_byte;
    logic [LenW-1:0]  encoded_length;
    logic             read_error;
  } result_t;

  function automatic int unsigned addr_width(int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

### hdl/rle_row_encoder.sv
// Run-length row encoder. Load requests (req_type 0) write one sample each into a
// single-port-write row memory; the sample flagged last_sample completes the row.
// Each read request (req_type 1) returns one encoded byte: a header, count or run
// value is issued from the decision state, and a literal byte is read from the
// memory and issued from the literal-output state. A packet boundary adds a
// look-ahead scan that reads the segment length plus up to three samples.
// Results sit in an output register, so the next request is taken while the last
// result is being collected. A read with no complete row returns read_error.
module rle_row_encoder #(
  parameter int unsigned MAX_ROW   = rre_pkg::MaxRowDefault,
  parameter int unsigned MAX_CHUNK = rre_pkg::MaxChunkDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic [rre_pkg::ByteW-1:0]  sample_i,
  input  logic                       last_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [rre_pkg::ByteW-1:0]  code_byte_o,
  output logic                       last_byte_o,
  output logic [rre_pkg::LenW-1:0]   encoded_length_o,
  output logic                       read_error_o
);

  localparam int unsigned AW = rre_pkg::addr_width(MAX_ROW);

  logic                      idle;
  logic                      req_acc;
  rre_pkg::result_t          res;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [rre_pkg::ByteW-1:0] mem_wdata;
  logic [AW-1:0]             mem_raddr;
  logic [rre_pkg::ByteW-1:0] mem_rdata;

  logic             out_valid_q, out_valid_d;
  rre_pkg::result_t out_q;

  assign in_stall_o = !idle || (out_valid_q && out_stall_i);
  assign req_acc    = in_valid_i && !in_stall_o;

  rre_ctrl #(
    .MAX_ROW  (MAX_ROW),
    .MAX_CHUNK(MAX_CHUNK),
    .AW       (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_acc_i    (req_acc),
    .req_type_i   (req_type_i),
    .sample_i     (sample_i),
    .last_sample_i(last_sample_i),
    .idle_o       (idle),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  rre_row_mem #(
    .DEPTH(MAX_ROW),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign code_byte_o      = out_q.code_byte;
  assign last_byte_o      = out_q.last_byte;
  assign encoded_length_o = out_q.encoded_length;
  assign read_error_o     = out_q.read_error;

endmodule

### hdl/rre_row_mem.sv
module rre_row_mem #(
  parameter int unsigned DEPTH = rre_pkg::MaxRowDefault,
  parameter int unsigned AW    = rre_pkg::addr_width(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [rre_pkg::ByteW-1:0] wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [rre_pkg::ByteW-1:0] rdata_o
);

  logic [rre_pkg::ByteW-1:0] mem [DEPTH];
  logic [rre_pkg::ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/rre_ctrl.sv
module rre_ctrl #(
  parameter int unsigned MAX_ROW   = rre_pkg::MaxRowDefault,
  parameter int unsigned MAX_CHUNK = rre_pkg::MaxChunkDefault,
  parameter int unsigned AW        = rre_pkg::addr_width(MAX_ROW)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_acc_i,
  input  logic                      req_type_i,
  input  logic [rre_pkg::ByteW-1:0] sample_i,
  input  logic                      last_sample_i,
  output logic                      idle_o,
  output rre_pkg::result_t          res_o,
  output logic                      mem_we_o,
  output logic [AW-1:0]             mem_waddr_o,
  output logic [rre_pkg::ByteW-1:0] mem_wdata_o,
  output logic [AW-1:0]             mem_raddr_o,
  input  logic [rre_pkg::ByteW-1:0] mem_rdata_i
);

  localparam int unsigned CntW = $clog2(MAX_ROW + 1);
  localparam logic [CntW-1:0] MaxRowC = CntW'(MAX_ROW);
  localparam logic [rre_pkg::RemW-1:0] ChunkC = rre_pkg::RemW'(MAX_CHUNK);

  rre_pkg::state_e state_q, state_d;
  rre_pkg::kind_e  kind_q, kind_d;
  logic [CntW-1:0] loaded_q, loaded_d;
  logic            complete_q, complete_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic [CntW-1:0] pend_q, pend_d;
  logic [CntW-1:0] addr_q, addr_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [rre_pkg::RemW-1:0]  rem_q, rem_d;
  logic [rre_pkg::ByteW-1:0] rv_q, rv_d;
  logic [rre_pkg::ByteW-1:0] b1_q, b1_d;
  logic [rre_pkg::ByteW-1:0] b2_q, b2_d;
  logic [1:0]                prime_q, prime_d;
  logic [rre_pkg::LenW-1:0]  emit_q, emit_d;

  logic [rre_pkg::RemW-1:0] chunk;
  logic [CntW-1:0]          ld_cnt;
  logic [CntW:0]            scan_p2;
  logic                     idx_end;

  always_comb begin
    chunk = (32'(pend_q) > 32'(MAX_CHUNK)) ? ChunkC : rre_pkg::RemW'(pend_q);
    ld_cnt = complete_q ? '0 : loaded_q;
    scan_p2 = {1'b0, scan_q} + (CntW + 1)'(2);
    idx_end = ({1'b0, idx_q} + (CntW + 1)'(1)) >= {1'b0, loaded_q};

    state_d    = state_q;
    kind_d     = kind_q;
    loaded_d   = loaded_q;
    complete_d = complete_q;
    scan_d     = scan_q;
    pend_d     = pend_q;
    addr_d     = addr_q;
    idx_d      = idx_q;
    rem_d      = rem_q;
    rv_d       = rv_q;
    b1_d       = b1_q;
    b2_d       = b2_q;
    prime_d    = prime_q;
    emit_d     = emit_q;

    res_o       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = ld_cnt[AW-1:0];
    mem_wdata_o = sample_i;
    mem_raddr_o = (state_q == rre_pkg::StDecide) ? scan_q[AW-1:0] : addr_q[AW-1:0];

    unique case (state_q)
      rre_pkg::StIdle: begin
        if (req_acc_i) begin
          if (req_type_i == rre_pkg::ReqLoad) begin
            complete_d = 1'b0;
            loaded_d   = ld_cnt;
            if (ld_cnt < MaxRowC) begin
              mem_we_o = 1'b1;
              loaded_d = ld_cnt + CntW'(1);
            end
            if (last_sample_i) begin
              complete_d = 1'b1;
              scan_d     = '0;
              kind_d     = rre_pkg::KindStart;
              rem_d      = '0;
              pend_d     = '0;
              rv_d       = '0;
              emit_d     = '0;
            end
          end else if (!complete_q) begin
            res_o.valid      = 1'b1;
            res_o.read_error = 1'b1;
          end else begin
            state_d = rre_pkg::StDecide;
          end
        end
      end
      rre_pkg::StDecide: begin
        unique case (kind_q)
          rre_pkg::KindLit: begin
            if (rem_q != '0) begin
              state_d = rre_pkg::StLitOut;
            end else if (pend_q != '0) begin
              rem_d           = chunk;
              pend_d          = pend_q - CntW'(chunk);
              res_o.valid     = 1'b1;
              res_o.code_byte = rre_pkg::LitHeader | {1'b0, chunk};
              emit_d          = emit_q + rre_pkg::LenW'(1);
              state_d         = rre_pkg::StIdle;
            end else begin
              addr_d  = scan_q + CntW'(1);
              idx_d   = scan_q;
              prime_d = 2'd0;
              state_d = rre_pkg::StRunScan;
            end
          end
          rre_pkg::KindRun: begin
            if (rem_q != '0) begin
              rem_d           = '0;
              res_o.valid     = 1'b1;
              res_o.code_byte = rv_q;
              emit_d          = emit_q + rre_pkg::LenW'(1);
              state_d         = rre_pkg::StIdle;
            end else if (pend_q != '0) begin
              rem_d           = rre_pkg::RemW'(1);
              pend_d          = pend_q - CntW'(chunk);
              res_o.valid     = 1'b1;
              res_o.code_byte = {1'b0, chunk};
              emit_d          = emit_q + rre_pkg::LenW'(1);
              state_d         = rre_pkg::StIdle;
            end else begin
              kind_d = rre_pkg::KindStart;
            end
          end
          rre_pkg::KindStart: begin
            if (scan_q >= loaded_q) begin
              res_o.valid          = 1'b1;
              res_o.code_byte      = rre_pkg::Terminator;
              res_o.last_byte      = 1'b1;
              res_o.encoded_length = emit_q + rre_pkg::LenW'(1);
              complete_d = 1'b0;
              loaded_d   = '0;
              scan_d     = '0;
              kind_d     = rre_pkg::KindStart;
              rem_d      = '0;
              pend_d     = '0;
              rv_d       = '0;
              emit_d     = '0;
              state_d    = rre_pkg::StIdle;
            end else if (scan_p2 >= {1'b0, loaded_q}) begin
              pend_d = '0;
              rem_d  = '0;
              kind_d = rre_pkg::KindLit;
            end else begin
              addr_d  = scan_q + CntW'(1);
              idx_d   = scan_q;
              prime_d = 2'd0;
              state_d = rre_pkg::StLitScan;
            end
          end
          default: begin
            kind_d = rre_pkg::KindStart;
          end
        endcase
      end
      rre_pkg::StLitOut: begin
        rem_d           = rem_q - rre_pkg::RemW'(1);
        scan_d          = scan_q + CntW'(1);
        res_o.valid     = 1'b1;
        res_o.code_byte = mem_rdata_i;
        emit_d          = emit_q + rre_pkg::LenW'(1);
        state_d         = rre_pkg::StIdle;
      end
      rre_pkg::StLitScan: begin
        addr_d = addr_q + CntW'(1);
        idx_d  = addr_q;
        if (prime_q != 2'd2) begin
          b2_d    = b1_q;
          b1_d    = mem_rdata_i;
          prime_d = prime_q + 2'd1;
        end else if (b2_q == b1_q && b1_q == mem_rdata_i) begin
          pend_d  = idx_q - scan_q - CntW'(2);
          rem_d   = '0;
          kind_d  = rre_pkg::KindLit;
          state_d = rre_pkg::StDecide;
        end else if (idx_end) begin
          pend_d  = idx_q - scan_q - CntW'(1);
          rem_d   = '0;
          kind_d  = rre_pkg::KindLit;
          state_d = rre_pkg::StDecide;
        end else begin
          b2_d = b1_q;
          b1_d = mem_rdata_i;
        end
      end
      rre_pkg::StRunScan: begin
        addr_d = addr_q + CntW'(1);
        idx_d  = addr_q;
        if (prime_q == 2'd0) begin
          rv_d    = mem_rdata_i;
          prime_d = 2'd1;
          if (idx_end) begin
            pend_d  = CntW'(1);
            scan_d  = scan_q + CntW'(1);
            rem_d   = '0;
            kind_d  = rre_pkg::KindRun;
            state_d = rre_pkg::StDecide;
          end
        end else if (mem_rdata_i != rv_q) begin
          pend_d  = idx_q - scan_q;
          scan_d  = idx_q;
          rem_d   = '0;
          kind_d  = rre_pkg::KindRun;
          state_d = rre_pkg::StDecide;
        end else if (idx_end) begin
          pend_d  = idx_q - scan_q + CntW'(1);
          scan_d  = idx_q + CntW'(1);
          rem_d   = '0;
          kind_d  = rre_pkg::KindRun;
          state_d = rre_pkg::StDecide;
        end
      end
      default: begin
        state_d = rre_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rre_pkg::StIdle;
      kind_q     <= rre_pkg::KindStart;
      loaded_q   <= '0;
      complete_q <= 1'b0;
      scan_q     <= '0;
      pend_q     <= '0;
      rem_q      <= '0;
      rv_q       <= '0;
      emit_q     <= '0;
      prime_q    <= '0;
    end else begin
      state_q    <= state_d;
      kind_q     <= kind_d;
      loaded_q   <= loaded_d;
      complete_q <= complete_d;
      scan_q     <= scan_d;
      pend_q     <= pend_d;
      rem_q      <= rem_d;
      rv_q       <= rv_d;
      emit_q     <= emit_d;
      prime_q    <= prime_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    idx_q  <= idx_d;
    b1_q   <= b1_d;
    b2_q   <= b2_d;
  end

  assign idle_o = (state_q == rre_pkg::StIdle);

  a_rem_in_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(rem_q) <= 32'(MAX_CHUNK))
    else $error("packet count above chunk limit");

  a_no_result_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rre_pkg::StLitScan || state_q == rre_pkg::StRunScan) |-> !res_o.valid)
    else $error("result issued mid-scan");

  a_scan_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete_q |-> scan_q <= loaded_q)
    else $error("scan position beyond row");

  a_read_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idle_o && req_acc_i && req_type_i == rre_pkg::ReqRead && complete_q)
      |=> state_q == rre_pkg::StDecide)
    else $error("read request on complete row not started");

  a_busy_holds_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idle_o |-> complete_q)
    else $error("encoder busy without a complete row");

endmodule

### verif/rle_row_encoder_tb.sv
module rle_row_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StuckLimit = 40000;
  localparam int unsigned SettleCycles = 50;
  localparam int unsigned RandomItems = 1750;

  typedef struct packed {
    logic                      req;
    logic [rre_pkg::ByteW-1:0] smp;
    logic                      last;
  } enc_req_t;

  typedef struct packed {
    logic [rre_pkg::ByteW-1:0] code_byte;
    logic                      last_byte;
    logic [rre_pkg::LenW-1:0]  encoded_length;
    logic                      read_error;
  } code_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      req_type_i = rre_pkg::ReqLoad;
  logic [rre_pkg::ByteW-1:0] sample_i = '0;
  logic                      last_sample_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [rre_pkg::ByteW-1:0] code_byte_o;
  logic                      last_byte_o;
  logic [rre_pkg::LenW-1:0]  encoded_length_o;
  logic                      read_error_o;

  rle_row_encoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .sample_i        (sample_i),
    .last_sample_i   (last_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .code_byte_o     (code_byte_o),
    .last_byte_o     (last_byte_o),
    .encoded_length_o(encoded_length_o),
    .read_error_o    (read_error_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // stimulus queue and its own view of the row, used only to size the reads
  enc_req_t                  request_q[$];
  int unsigned               n_items = 0;
  logic [rre_pkg::ByteW-1:0] stim_row[$];
  logic                      stim_done = 1'b0;
  int unsigned               stim_left = 0;

  // encoder state
  logic [rre_pkg::ByteW-1:0] row_bytes[$];
  logic                      row_done = 1'b0;
  int unsigned               scan_pos = 0;
  rre_pkg::kind_e            pkt_kind = rre_pkg::KindStart;
  int unsigned               pkt_left = 0;
  int unsigned               run_left = 0;
  logic [rre_pkg::ByteW-1:0] run_byte = '0;
  int unsigned               out_count = 0;

  code_t                     pending_codes[$];
  int unsigned               mismatches = 0;
  int unsigned               offered_cnt = 0;
  int unsigned               taken_cnt = 0;
  int unsigned               stuck_cycles = 0;

  int unsigned               in_gap = 0;
  int unsigned               out_gap = 0;
  int unsigned               mode_timer = 0;
  int unsigned               idle_mode = 1;

  function automatic int unsigned lit_span(input logic [rre_pkg::ByteW-1:0] r[$],
                                           input int unsigned p);
    int unsigned i;
    i = p + 2;
    while (i < r.size() && !(r[i-2] == r[i-1] && r[i-1] == r[i])) i++;
    return i - 2 - p;
  endfunction

  function automatic int unsigned rep_span(input logic [rre_pkg::ByteW-1:0] r[$],
                                           input int unsigned p);
    int unsigned i;
    i = p + 1;
    while (i < r.size() && r[i] == r[p]) i++;
    return i - p;
  endfunction

  function automatic int unsigned chunks(input int unsigned n);
    return (n + rre_pkg::MaxChunkDefault - 1) / rre_pkg::MaxChunkDefault;
  endfunction

  function automatic int unsigned row_code_len(input logic [rre_pkg::ByteW-1:0] r[$]);
    int unsigned p, seg, total;
    p = 0;
    total = 1;
    while (p < r.size()) begin
      seg = lit_span(r, p);
      total += seg + chunks(seg);
      p += seg;
      seg = rep_span(r, p);
      total += 2 * chunks(seg);
      p += seg;
    end
    return total;
  endfunction

  task automatic push_load(input logic [rre_pkg::ByteW-1:0] smp, input logic last);
    request_q.push_back('{req: rre_pkg::ReqLoad, smp: smp, last: last});
    n_items++;
    if (stim_done) begin
      stim_done = 1'b0;
      stim_row.delete();
    end
    if (stim_row.size() < rre_pkg::MaxRowDefault) stim_row.push_back(smp);
    if (last) begin
      stim_done = 1'b1;
      stim_left = row_code_len(stim_row);
    end
  endtask

  task automatic push_read();
    request_q.push_back('{req: rre_pkg::ReqRead, smp: 8'($urandom), last: 1'($urandom)});
    n_items++;
    if (stim_done) begin
      stim_left--;
      if (stim_left == 0) begin
        stim_done = 1'b0;
        stim_row.delete();
      end
    end
  endtask

  task automatic finish_row();
    while (stim_done) push_read();
  endtask

  // style: 0 full range, 1 two-value alphabet, 2 long runs, 3 never three equal
  task automatic add_row(input int unsigned len, input int style);
    logic [rre_pkg::ByteW-1:0] v, p1, p2, a0, a1;
    a0 = 8'($urandom);
    a1 = 8'($urandom);
    v = 8'($urandom);
    p1 = '0;
    p2 = '0;
    for (int unsigned k = 0; k < len; k++) begin
      case (style)
        0: v = 8'($urandom);
        1: v = $urandom_range(0, 1) ? a1 : a0;
        2: if ($urandom_range(0, 24) == 0) v = 8'($urandom);
        default: begin
          v = 8'($urandom);
          if (k >= 2 && p1 == p2 && v == p1) v = ~v;
        end
      endcase
      p2 = p1;
      p1 = v;
      push_load(v, k == len - 1);
    end
  endtask

  task automatic restart_scan();
    scan_pos = 0;
    pkt_kind = rre_pkg::KindStart;
    pkt_left = 0;
    run_left = 0;
    run_byte = '0;
    out_count = 0;
  endtask

  task automatic next_code_byte(output logic [rre_pkg::ByteW-1:0] b, output logic term);
    logic        done;
    int unsigned chunk;
    done = 1'b0;
    term = 1'b0;
    b = '0;
    while (!done) begin
      case (pkt_kind)
        rre_pkg::KindLit: begin
          if (pkt_left > 0) begin
            pkt_left--;
            b = row_bytes[scan_pos];
            scan_pos++;
            done = 1'b1;
          end else if (run_left > 0) begin
            pkt_left = (run_left > rre_pkg::MaxChunkDefault) ?
                       rre_pkg::MaxChunkDefault : run_left;
            run_left -= pkt_left;
            b = rre_pkg::LitHeader | 8'(pkt_left);
            done = 1'b1;
          end else begin
            run_byte = row_bytes[scan_pos];
            run_left = rep_span(row_bytes, scan_pos);
            scan_pos += run_left;
            pkt_kind = rre_pkg::KindRun;
            pkt_left = 0;
          end
        end
        rre_pkg::KindRun: begin
          if (pkt_left > 0) begin
            pkt_left = 0;
            b = run_byte;
            done = 1'b1;
          end else if (run_left > 0) begin
            chunk = (run_left > rre_pkg::MaxChunkDefault) ?
                    rre_pkg::MaxChunkDefault : run_left;
            run_left -= chunk;
            pkt_left = 1;
            b = 8'(chunk);
            done = 1'b1;
          end else begin
            pkt_kind = rre_pkg::KindStart;
          end
        end
        default: begin
          if (scan_pos >= row_bytes.size()) begin
            term = 1'b1;
            b = rre_pkg::Terminator;
            done = 1'b1;
          end else begin
            run_left = lit_span(row_bytes, scan_pos);
            pkt_kind = rre_pkg::KindLit;
            pkt_left = 0;
          end
        end
      endcase
    end
  endtask

  task automatic encode_request(input logic req, input logic [rre_pkg::ByteW-1:0] smp,
                                input logic last);
    code_t                     res;
    logic [rre_pkg::ByteW-1:0] b;
    logic                      term;
    res = '0;
    if (req == rre_pkg::ReqLoad) begin
      if (row_done) begin
        row_done = 1'b0;
        row_bytes.delete();
      end
      if (row_bytes.size() < rre_pkg::MaxRowDefault) row_bytes.push_back(smp);
      if (last) begin
        row_done = 1'b1;
        restart_scan();
      end
    end else if (!row_done) begin
      res.read_error = 1'b1;
      pending_codes.push_back(res);
    end else begin
      next_code_byte(b, term);
      out_count++;
      res.code_byte = b;
      res.last_byte = term;
      if (term) res.encoded_length = rre_pkg::LenW'(out_count);
      pending_codes.push_back(res);
      if (term) begin
        row_done = 1'b0;
        row_bytes.delete();
        restart_scan();
      end
    end
  endtask

  // driver: requests and output stall, changed on the falling edge
  always @(negedge clk_i) begin
    enc_req_t r;
    logic     calm;
    if (rst_ni) begin
      calm = request_q.size() < 250;
      mode_timer++;
      if (mode_timer == 300) begin
        mode_timer = 0;
        idle_mode = $urandom_range(0, 2);
      end

      if (offered_cnt == taken_cnt) begin
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap--;
        end else if (!calm && idle_mode != 0 &&
                     $urandom_range(0, idle_mode == 1 ? 15 : 4) == 0) begin
          in_valid_i <= 1'b0;
          in_gap = $urandom_range(0, 13);
        end else if (request_q.size() > 0) begin
          r = request_q.pop_front();
          req_type_i <= r.req;
          sample_i <= r.smp;
          last_sample_i <= r.last;
          in_valid_i <= 1'b1;
          offered_cnt++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end

      if (out_gap > 0) begin
        out_stall_i <= 1'b1;
        out_gap--;
      end else if (!calm && idle_mode != 0 &&
                   $urandom_range(0, idle_mode == 1 ? 15 : 4) == 0) begin
        out_stall_i <= 1'b1;
        out_gap = $urandom_range(0, 13);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // monitor: prediction, comparison and watchdog on the rising edge
  always @(posedge clk_i) begin
    code_t exp_c;
    logic  moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        encode_request(req_type_i, sample_i, last_sample_i);
        taken_cnt++;
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (pending_codes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: byte %02h last %0d len %0d err %0d",
                     code_byte_o, last_byte_o, encoded_length_o, read_error_o);
        end else begin
          exp_c = pending_codes.pop_front();
          if (exp_c.code_byte !== code_byte_o || exp_c.last_byte !== last_byte_o ||
              exp_c.encoded_length !== encoded_length_o ||
              exp_c.read_error !== read_error_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"bad result: exp byte %02h last %0d len %0d err %0d,",
                        " got byte %02h last %0d len %0d err %0d"},
                       exp_c.code_byte, exp_c.last_byte, exp_c.encoded_length,
                       exp_c.read_error, code_byte_o, last_byte_o, encoded_length_o,
                       read_error_o);
          end
        end
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles == StuckLimit) begin
        $display("rle_row_encoder: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick, len;
    int          style;

    // read with nothing loaded
    push_read();
    // two runs of one byte each, then a read past the terminator
    push_load(8'h00, 1'b0);
    push_load(8'hFF, 1'b1);
    finish_row();
    push_read();
    // single-sample row
    push_load(8'h5A, 1'b1);
    finish_row();
    // literal then a run of three
    push_load(8'h01, 1'b0);
    push_load(8'h02, 1'b0);
    push_load(8'h03, 1'b0);
    push_load(8'h03, 1'b0);
    push_load(8'h03, 1'b1);
    finish_row();

    while (n_items < RandomItems) begin
      pick = $urandom_range(0, 19);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(127, 300) : $urandom_range(1, 40);
      style = $urandom_range(0, 3);
      if (pick < 15) begin
        add_row(len, style);
        finish_row();
        if ($urandom_range(0, 4) == 0) push_read();
      end else if (pick < 17) begin
        // row abandoned part way through the drain
        add_row(len, style);
        repeat ($urandom_range(0, stim_left - 1)) push_read();
      end else begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 1)) push_read();
          else push_load(8'($urandom), 1'b0);
        end
      end
    end
    finish_row();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (request_q.size() != 0 || offered_cnt != taken_cnt || pending_codes.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);

    if (mismatches == 0 && pending_codes.size() == 0) begin
      $display("rle_row_encoder: match");
    end else begin
      $display("rle_row_encoder: mismatch");
    end
    $finish;
  end

endmodule
